FILE: sv/uart_rb_pkg.sv
// Shared types, codes and helper functions for the UART register block.
// No dependencies; the control logic, top level and testbench import it.
`timescale 1ns / 1ps

package uart_rb_pkg;

  localparam int unsigned FifoDepthDefault = 64;
  localparam int unsigned LvlW = 7;  // width for capacity and trigger levels

  // Item kinds carried on tuser.
  localparam logic [2:0] CMD_READ    = 3'd0;
  localparam logic [2:0] CMD_WRITE   = 3'd1;
  localparam logic [2:0] CMD_RX_BYTE = 3'd2;
  localparam logic [2:0] CMD_TX_DONE = 3'd3;
  localparam logic [2:0] CMD_TIMEOUT = 3'd4;

  // Register offsets.
  localparam logic [2:0] REG_DATA = 3'd0;
  localparam logic [2:0] REG_IER  = 3'd1;
  localparam logic [2:0] REG_IIR  = 3'd2;
  localparam logic [2:0] REG_LCR  = 3'd3;
  localparam logic [2:0] REG_MCR  = 3'd4;
  localparam logic [2:0] REG_LSR  = 3'd5;
  localparam logic [2:0] REG_MSR  = 3'd6;
  localparam logic [2:0] REG_SCR  = 3'd7;

  // Interrupt identification codes.
  localparam logic [3:0] IIR_NONE = 4'b0001;
  localparam logic [3:0] IIR_LINE = 4'b0110;
  localparam logic [3:0] IIR_RXD  = 4'b0100;
  localparam logic [3:0] IIR_TOUT = 4'b1100;
  localparam logic [3:0] IIR_THRE = 4'b0010;

  localparam logic [1:0] VAR_NONE = 2'd0;
  localparam logic [1:0] VAR_16   = 2'd1;
  localparam logic [1:0] VAR_64   = 2'd2;

  // Result handed from the control logic to the output stage.
  typedef struct packed {
    logic [7:0]  read_data;
    logic        rd_from_mem;
    logic        irq;
    logic        tx_start;
    logic        tx_from_mem;
    logic [7:0]  tx_byte;
    logic [15:0] divisor;
  } res_t;

  function automatic logic fifo_on(input logic [1:0] variant, input logic [3:0] fcr);
    return (variant != VAR_NONE) && fcr[0];
  endfunction

  function automatic logic mode64(input logic [1:0] variant, input logic [3:0] fcr);
    return fifo_on(variant, fcr) && (variant == VAR_64) && fcr[1];
  endfunction

  // Capacity before the clamp to the physical depth.
  function automatic logic [LvlW-1:0] cap_raw(input logic [1:0] variant,
                                              input logic [3:0] fcr);
    logic [LvlW-1:0] c;
    c = 7'd1;
    if (fifo_on(variant, fcr)) begin
      c = mode64(variant, fcr) ? 7'd64 : 7'd16;
    end
    return c;
  endfunction

  // Trigger level before the clamp to the capacity.
  function automatic logic [LvlW-1:0] trig_raw(input logic [1:0] variant,
                                               input logic [3:0] fcr);
    logic [LvlW-1:0] t;
    t = 7'd1;
    if (mode64(variant, fcr)) begin
      unique case (fcr[3:2])
        2'd0: t = 7'd1;
        2'd1: t = 7'd16;
        2'd2: t = 7'd32;
        default: t = 7'd56;
      endcase
    end else if (fifo_on(variant, fcr)) begin
      unique case (fcr[3:2])
        2'd0: t = 7'd1;
        2'd1: t = 7'd4;
        2'd2: t = 7'd8;
        default: t = 7'd14;
      endcase
    end
    return t;
  endfunction

  function automatic logic [3:0] ident(input logic [3:0] ier, input logic [3:0] lerr,
                                       input logic [LvlW-1:0] rxc,
                                       input logic [LvlW-1:0] trig,
                                       input logic tout, input logic thre);
    logic [3:0] id;
    id = IIR_NONE;
    if (ier[2] && (lerr != 4'd0)) begin
      id = IIR_LINE;
    end else if (ier[0] && (rxc != 7'd0) && (rxc >= trig)) begin
      id = IIR_RXD;
    end else if (ier[0] && tout) begin
      id = IIR_TOUT;
    end else if (ier[1] && thre) begin
      id = IIR_THRE;
    end
    return id;
  endfunction

endpackage

FILE: sv/uart_rb_fifo_mem.sv
// Synchronous byte memory with one write port and one registered read port.
// Depends on nothing; used for the receive and transmit FIFO storage.
`timescale 1ns / 1ps

module uart_rb_fifo_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued, so a stalled result keeps its byte.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/uart_rb_ctrl.sv
// Register file, FIFO pointers and event handling of the UART register block.
// Depends on uart_rb_pkg; drives the write and read ports of both FIFO memories.
`timescale 1ns / 1ps

module uart_rb_ctrl
  import uart_rb_pkg::*;
#(
  parameter int unsigned FifoDepth = FifoDepthDefault,
  parameter int unsigned AddrW     = $clog2(FifoDepth),
  parameter int unsigned CntW      = $clog2(FifoDepth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  input  logic             fire_i,
  input  logic [2:0]       cmd_i,
  input  logic [2:0]       reg_addr_i,
  input  logic [7:0]       write_data_i,
  input  logic [7:0]       line_byte_i,
  input  logic             parity_error_i,
  input  logic             framing_error_i,
  input  logic             break_seen_i,
  output logic             rx_we_o,
  output logic [AddrW-1:0] rx_waddr_o,
  output logic [7:0]       rx_wdata_o,
  output logic [AddrW-1:0] rx_raddr_o,
  output logic             tx_we_o,
  output logic [AddrW-1:0] tx_waddr_o,
  output logic [7:0]       tx_wdata_o,
  output logic [AddrW-1:0] tx_raddr_o,
  output res_t             res_o
);

  localparam logic [LvlW-1:0] DepthLvl = LvlW'(FifoDepth);

  logic [1:0]      variant_q, variant_d;
  logic [CntW-1:0] rxc_q, rxc_d, txc_q, txc_d;
  logic [AddrW-1:0] rxh_q, rxh_d, txh_q, txh_d;
  logic            busy_q, busy_d;
  logic [3:0]      ier_q, ier_d, fcr_q, fcr_d, lerr_q, lerr_d;
  logic [7:0]      lcr_q, lcr_d, scr_q, scr_d;
  logic [4:0]      mcr_q, mcr_d;
  logic [15:0]     dl_q, dl_d;
  logic            thre_q, thre_d, tout_q, tout_d;

  logic [LvlW-1:0] cap_now, trig_now, cap_nxt, trig_nxt;
  logic [LvlW-1:0] rxc_lvl, txc_lvl;
  logic            on_now, m64_now, dlab;
  logic [3:0]      id_now, id_nxt;
  logic [1:0]      cfg_v;
  logic [7:0]      rx_byte;

  function automatic logic [AddrW-1:0] wrap_add(input logic [AddrW-1:0] h,
                                                input logic [CntW-1:0] c);
    logic [AddrW:0] s;
    s = (AddrW+1)'(h) + (AddrW+1)'(c);
    if (s >= (AddrW+1)'(FifoDepth)) begin
      s = s - (AddrW+1)'(FifoDepth);
    end
    return s[AddrW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] wrap_inc(input logic [AddrW-1:0] h);
    return (h == AddrW'(FifoDepth - 1)) ? '0 : h + 1'b1;
  endfunction

  always_comb begin
    on_now   = fifo_on(variant_q, fcr_q);
    m64_now  = mode64(variant_q, fcr_q);
    cap_now  = (cap_raw(variant_q, fcr_q) > DepthLvl) ? DepthLvl : cap_raw(variant_q, fcr_q);
    trig_now = (trig_raw(variant_q, fcr_q) > cap_now) ? cap_now : trig_raw(variant_q, fcr_q);
    rxc_lvl  = LvlW'(rxc_q);
    txc_lvl  = LvlW'(txc_q);
    dlab     = lcr_q[7];
    id_now   = ident(ier_q, lerr_q, rxc_lvl, trig_now, tout_q, thre_q);
    cfg_v    = (cfg_wdata_i == 2'd3) ? VAR_64 : cfg_wdata_i;
    rx_byte  = break_seen_i ? 8'd0 : line_byte_i;
  end

  always_comb begin
    variant_d = variant_q;
    rxc_d = rxc_q;  rxh_d = rxh_q;  txc_d = txc_q;  txh_d = txh_q;
    busy_d = busy_q;  ier_d = ier_q;  fcr_d = fcr_q;  lerr_d = lerr_q;
    lcr_d = lcr_q;  scr_d = scr_q;  mcr_d = mcr_q;  dl_d = dl_q;
    thre_d = thre_q;  tout_d = tout_q;

    rx_we_o    = 1'b0;
    rx_waddr_o = wrap_add(rxh_q, rxc_q);
    rx_wdata_o = rx_byte;
    tx_we_o    = 1'b0;
    tx_waddr_o = wrap_add(txh_q, txc_q);
    tx_wdata_o = write_data_i;

    res_o = '0;

    priority if (cfg_we_i) begin
      if (cfg_v != variant_q) begin
        variant_d = cfg_v;
        rxc_d = '0;  rxh_d = '0;  tout_d = 1'b0;
        txc_d = '0;  txh_d = '0;
        if (cfg_v == VAR_NONE) begin
          fcr_d = 4'd0;
        end else if (cfg_v == VAR_16) begin
          fcr_d = {fcr_q[3:2], 1'b0, fcr_q[0]};
        end
      end
    end else if (fire_i) begin
      unique case (cmd_i)
        CMD_READ: begin
          unique case (reg_addr_i)
            REG_DATA: begin
              if (dlab) begin
                res_o.read_data = dl_q[7:0];
              end else if (rxc_q != '0) begin
                res_o.rd_from_mem = 1'b1;
                rxh_d  = wrap_inc(rxh_q);
                rxc_d  = rxc_q - 1'b1;
                tout_d = 1'b0;
              end
            end
            REG_IER: res_o.read_data = dlab ? dl_q[15:8] : {4'd0, ier_q};
            REG_IIR: begin
              if (id_now == IIR_THRE) begin
                thre_d = 1'b0;
              end
              res_o.read_data = {on_now, on_now, m64_now, 1'b0, id_now};
            end
            REG_LCR: res_o.read_data = lcr_q;
            REG_MCR: res_o.read_data = {3'd0, mcr_q};
            REG_LSR: begin
              res_o.read_data = {on_now && (lerr_q[3:1] != 3'd0),
                                 (txc_q == '0) && !busy_q,
                                 txc_q == '0,
                                 lerr_q,
                                 rxc_q != '0};
              lerr_d = 4'd0;
            end
            REG_SCR: res_o.read_data = scr_q;
            default: res_o.read_data = 8'd0;
          endcase
        end
        CMD_WRITE: begin
          unique case (reg_addr_i)
            REG_DATA: begin
              if (dlab) begin
                dl_d[7:0] = write_data_i;
              end else if ((txc_q == '0) && !busy_q) begin
                busy_d = 1'b1;
                thre_d = 1'b1;
                res_o.tx_start = 1'b1;
                res_o.tx_byte  = write_data_i;
              end else if (txc_lvl < cap_now) begin
                tx_we_o = 1'b1;
                txc_d   = txc_q + 1'b1;
                thre_d  = 1'b0;
              end
            end
            REG_IER: begin
              if (dlab) begin
                dl_d[15:8] = write_data_i;
              end else begin
                ier_d = write_data_i[3:0];
                if (write_data_i[1] && (txc_q == '0)) begin
                  thre_d = 1'b1;
                end
              end
            end
            REG_IIR: begin
              if (variant_q != VAR_NONE) begin
                fcr_d = write_data_i[0] ?
                        {write_data_i[7:6],
                         (variant_q == VAR_64) && write_data_i[5], 1'b1} : 4'd0;
                // Turning the FIFOs on or off empties both of them.
                if ((fcr_q[0] != write_data_i[0]) ||
                    (write_data_i[0] && write_data_i[1])) begin
                  rxc_d = '0;  rxh_d = '0;  tout_d = 1'b0;
                end
                if ((fcr_q[0] != write_data_i[0]) ||
                    (write_data_i[0] && write_data_i[2])) begin
                  txc_d = '0;  txh_d = '0;
                end
              end
            end
            REG_LCR: lcr_d = write_data_i;
            REG_MCR: mcr_d = write_data_i[4:0];
            REG_SCR: scr_d = write_data_i;
            default: ;
          endcase
        end
        CMD_RX_BYTE: begin
          lerr_d = lerr_q | {break_seen_i, framing_error_i, parity_error_i, 1'b0};
          tout_d = 1'b0;
          if (rxc_lvl < cap_now) begin
            rx_we_o = 1'b1;
            rxc_d   = rxc_q + 1'b1;
          end else begin
            lerr_d[0] = 1'b1;
            // In one-byte mode the held character is replaced.
            if (!on_now) begin
              rx_we_o    = 1'b1;
              rx_waddr_o = rxh_q;
            end
          end
        end
        CMD_TX_DONE: begin
          if (txc_q != '0) begin
            res_o.tx_start    = 1'b1;
            res_o.tx_from_mem = 1'b1;
            txh_d  = wrap_inc(txh_q);
            txc_d  = txc_q - 1'b1;
            busy_d = 1'b1;
            if (txc_q == CntW'(1)) begin
              thre_d = 1'b1;
            end
          end else begin
            busy_d = 1'b0;
          end
        end
        CMD_TIMEOUT: begin
          if (on_now && (rxc_q != '0)) begin
            tout_d = 1'b1;
          end
        end
        default: ;
      endcase
    end

    cap_nxt  = (cap_raw(variant_d, fcr_d) > DepthLvl) ? DepthLvl : cap_raw(variant_d, fcr_d);
    trig_nxt = (trig_raw(variant_d, fcr_d) > cap_nxt) ? cap_nxt : trig_raw(variant_d, fcr_d);
    id_nxt   = ident(ier_d, lerr_d, LvlW'(rxc_d), trig_nxt, tout_d, thre_d);
    res_o.irq     = (id_nxt != IIR_NONE) && mcr_d[3];
    res_o.divisor = dl_d;
  end

  assign rx_raddr_o = rxh_q;
  assign tx_raddr_o = txh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= VAR_64;
      rxc_q <= '0;  rxh_q <= '0;  txc_q <= '0;  txh_q <= '0;
      busy_q <= 1'b0;  ier_q <= 4'd0;  fcr_q <= 4'd0;  lerr_q <= 4'd0;
      lcr_q <= 8'd0;  scr_q <= 8'd0;  mcr_q <= 5'd0;  dl_q <= 16'd0;
      thre_q <= 1'b0;  tout_q <= 1'b0;
    end else begin
      variant_q <= variant_d;
      rxc_q <= rxc_d;  rxh_q <= rxh_d;  txc_q <= txc_d;  txh_q <= txh_d;
      busy_q <= busy_d;  ier_q <= ier_d;  fcr_q <= fcr_d;  lerr_q <= lerr_d;
      lcr_q <= lcr_d;  scr_q <= scr_d;  mcr_q <= mcr_d;  dl_q <= dl_d;
      thre_q <= thre_d;  tout_q <= tout_d;
    end
  end

endmodule

FILE: sv/uart_register_block.sv
// Top level of the 16550-style UART register block: stream ports, output stage.
// Depends on uart_rb_pkg, uart_rb_ctrl and uart_rb_fifo_mem.
//
//  Channel   Direction  Content
//  s_axis    in         tuser = cmd; tdata = reg_addr, write_data, line_byte, flags
//  m_axis    out        tdata = read_data, irq_out, tx_start, tx_byte, baud_divisor
//  cfg       in         fifo_variant write, no read-back
//
// One item per cycle unless the output stalls; a result appears in the cycle
// after its transfer, as FIFO bytes come from the registered memory read port.
// Reset is asynchronous and clears all control state; FIFO storage is not cleared.
// When the output is stalled the result and its memory read data hold, and
// s_axis_tready falls until the result is taken.
`timescale 1ns / 1ps

module uart_register_block
  import uart_rb_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] reg_addr, [10:3] write_data, [18:11] line_byte, [19] parity_error,
  // [20] framing_error, [21] break_seen, [23:22] zero
  input  logic [23:0] s_axis_tdata,
  // [2:0] cmd
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_data, [8] irq_out, [9] tx_start, [17:10] tx_byte,
  // [33:18] baud_divisor, [39:34] zero
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned AddrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW  = $clog2(FIFO_DEPTH + 1);

  logic             fire;
  logic             vld_q, vld_d;
  res_t             res, res_q;
  logic             rx_we, tx_we;
  logic [AddrW-1:0] rx_waddr, rx_raddr, tx_waddr, tx_raddr;
  logic [7:0]       rx_wdata, tx_wdata, rx_rdata, tx_rdata;
  logic [7:0]       out_read, out_tx;

  assign s_axis_tready = !vld_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  uart_rb_ctrl #(
    .FifoDepth (FIFO_DEPTH),
    .AddrW     (AddrW),
    .CntW      (CntW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .fire_i          (fire),
    .cmd_i           (s_axis_tuser),
    .reg_addr_i      (s_axis_tdata[2:0]),
    .write_data_i    (s_axis_tdata[10:3]),
    .line_byte_i     (s_axis_tdata[18:11]),
    .parity_error_i  (s_axis_tdata[19]),
    .framing_error_i (s_axis_tdata[20]),
    .break_seen_i    (s_axis_tdata[21]),
    .rx_we_o         (rx_we),
    .rx_waddr_o      (rx_waddr),
    .rx_wdata_o      (rx_wdata),
    .rx_raddr_o      (rx_raddr),
    .tx_we_o         (tx_we),
    .tx_waddr_o      (tx_waddr),
    .tx_wdata_o      (tx_wdata),
    .tx_raddr_o      (tx_raddr),
    .res_o           (res)
  );

  uart_rb_fifo_mem #(
    .Depth (FIFO_DEPTH),
    .AddrW (AddrW)
  ) u_rx_mem (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (rx_wdata),
    .re_i    (fire),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  uart_rb_fifo_mem #(
    .Depth (FIFO_DEPTH),
    .AddrW (AddrW)
  ) u_tx_mem (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (tx_wdata),
    .re_i    (fire),
    .raddr_i (tx_raddr),
    .rdata_o (tx_rdata)
  );

  assign vld_d = fire || (vld_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_read = res_q.rd_from_mem ? rx_rdata : res_q.read_data;
  assign out_tx   = res_q.tx_from_mem ? tx_rdata : res_q.tx_byte;

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {6'd0, res_q.divisor, out_tx, res_q.tx_start, res_q.irq, out_read};

endmodule

FILE: test/uart_register_block_tb.sv
// Testbench for the UART register block: drives bus accesses and line events
// over the input stream, predicts every result and checks the output stream.
// Depends on uart_rb_pkg and the uart_register_block RTL.
`timescale 1ns / 1ps

module uart_register_block_tb;
  import uart_rb_pkg::*;

  localparam int Depth = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  uart_register_block #(.FIFO_DEPTH(Depth)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // Predicted register state.
  logic [1:0]  p_variant;
  logic [7:0]  p_rx [Depth];
  logic [7:0]  p_tx [Depth];
  int          p_rxc, p_rxh, p_txc, p_txh;
  logic        p_busy, p_thre, p_tout;
  logic [3:0]  p_ier, p_fcr, p_lerr;
  logic [7:0]  p_lcr, p_scr;
  logic [4:0]  p_mcr;
  logic [15:0] p_div;

  logic [39:0] expected_results [$];
  int  errors = 0;
  bit  long_stall = 0;
  int  gap_max = 3;

  function automatic bit p_fifo_on();
    return p_variant != VAR_NONE && p_fcr[0];
  endfunction
  function automatic bit p_mode64();
    return p_fifo_on() && p_variant == VAR_64 && p_fcr[1];
  endfunction
  function automatic int p_capacity();
    return p_fifo_on() ? (p_mode64() ? 64 : 16) : 1;
  endfunction
  function automatic int p_trigger();
    int t;
    int lv16 [4] = '{1, 4, 8, 14};
    int lv64 [4] = '{1, 16, 32, 56};
    t = 1;
    if (p_fifo_on()) t = p_mode64() ? lv64[p_fcr[3:2]] : lv16[p_fcr[3:2]];
    return (t > p_capacity()) ? p_capacity() : t;
  endfunction
  function automatic logic [3:0] p_ident();
    if (p_ier[2] && p_lerr != 0) return IIR_LINE;
    if (p_ier[0] && p_rxc > 0 && p_rxc >= p_trigger()) return IIR_RXD;
    if (p_ier[0] && p_tout) return IIR_TOUT;
    if (p_ier[1] && p_thre) return IIR_THRE;
    return IIR_NONE;
  endfunction

  function automatic void flush_rx();
    p_rxc = 0; p_rxh = 0; p_tout = 0;
  endfunction
  function automatic void flush_tx();
    p_txc = 0; p_txh = 0;
  endfunction

  function automatic void model_reset();
    flush_rx(); flush_tx();
    p_busy = 0; p_ier = 0; p_fcr = 0; p_lcr = 0; p_mcr = 0; p_div = 0;
    p_scr = 0; p_lerr = 0; p_thre = 0; p_variant = VAR_64;
  endfunction

  function automatic void model_variant(logic [1:0] value);
    logic [1:0] v;
    v = (value == 2'd3) ? VAR_64 : value;
    if (v == p_variant) return;
    p_variant = v;
    flush_rx(); flush_tx();
    if (v == VAR_NONE) p_fcr = 0;
    else if (v == VAR_16) p_fcr[1] = 1'b0;
  endfunction

  function automatic logic [7:0] model_read(logic [2:0] a);
    logic [7:0] r;
    logic [3:0] id;
    r = 0;
    case (a)
      REG_DATA: begin
        if (p_lcr[7]) r = p_div[7:0];
        else if (p_rxc > 0) begin
          r = p_rx[p_rxh]; p_rxh = (p_rxh + 1) % Depth; p_rxc--; p_tout = 0;
        end
      end
      REG_IER: r = p_lcr[7] ? p_div[15:8] : {4'd0, p_ier};
      REG_IIR: begin
        id = p_ident();
        if (id == IIR_THRE) p_thre = 0;
        r = {p_fifo_on() ? 2'b11 : 2'b00, p_mode64(), 1'b0, id};
      end
      REG_LCR: r = p_lcr;
      REG_MCR: r = {3'd0, p_mcr};
      REG_LSR: begin
        r = {3'd0, p_lerr, p_rxc > 0};
        if (p_txc == 0) r[5] = 1;
        if (p_txc == 0 && !p_busy) r[6] = 1;
        if (p_fifo_on() && p_lerr[3:1] != 0) r[7] = 1;
        p_lerr = 0;
      end
      REG_SCR: r = p_scr;
      default: r = 0;
    endcase
    return r;
  endfunction

  // Applies one input item to the predicted state and returns the result word.
  function automatic logic [39:0] uart_predict(logic [2:0] cmd, logic [23:0] d);
    logic [2:0] a;
    logic [7:0] wd, lb, rd, txb;
    logic pe, fe, br, txs, old_on;
    a = d[2:0]; wd = d[10:3]; lb = d[18:11]; pe = d[19]; fe = d[20]; br = d[21];
    rd = 0; txs = 0; txb = 0;
    case (cmd)
      CMD_READ: rd = model_read(a);
      CMD_WRITE: begin
        case (a)
          REG_DATA: begin
            if (p_lcr[7]) p_div[7:0] = wd;
            else if (p_txc == 0 && !p_busy) begin
              p_busy = 1; txs = 1; txb = wd; p_thre = 1;
            end else if (p_txc < p_capacity()) begin
              p_tx[(p_txh + p_txc) % Depth] = wd; p_txc++; p_thre = 0;
            end
          end
          REG_IER: begin
            if (p_lcr[7]) p_div[15:8] = wd;
            else begin
              p_ier = wd[3:0];
              if (wd[1] && p_txc == 0) p_thre = 1;
            end
          end
          REG_IIR: begin
            if (p_variant != VAR_NONE) begin
              old_on = p_fcr[0];
              if (!wd[0]) p_fcr = 0;
              else p_fcr = {wd[7:6], p_variant == VAR_64 && wd[5], 1'b1};
              if (old_on != p_fcr[0]) begin flush_rx(); flush_tx(); end
              if (wd[0] && wd[1]) flush_rx();
              if (wd[0] && wd[2]) flush_tx();
            end
          end
          REG_LCR: p_lcr = wd;
          REG_MCR: p_mcr = wd[4:0];
          REG_SCR: p_scr = wd;
          default: ;
        endcase
      end
      CMD_RX_BYTE: begin
        if (br) lb = 0;
        p_lerr = p_lerr | {br, fe, pe, 1'b0};
        p_tout = 0;
        if (p_rxc < p_capacity()) begin
          p_rx[(p_rxh + p_rxc) % Depth] = lb; p_rxc++;
        end else begin
          p_lerr[0] = 1;
          if (!p_fifo_on()) p_rx[p_rxh] = lb;
        end
      end
      CMD_TX_DONE: begin
        if (p_txc > 0) begin
          txs = 1; txb = p_tx[p_txh]; p_txh = (p_txh + 1) % Depth; p_txc--;
          p_busy = 1;
          if (p_txc == 0) p_thre = 1;
        end else p_busy = 0;
      end
      CMD_TIMEOUT: if (p_fifo_on() && p_rxc > 0) p_tout = 1;
      default: ;
    endcase
    return {6'd0, p_div, txb, txs, p_ident() != IIR_NONE && p_mcr[3], rd};
  endfunction

  // Sends one item; a read of an empty receive FIFO returns zero, so the
  // ring is never read before a write. Valid stays high after the transfer
  // until the next item, a gap or a drain takes it over.
  task automatic send_item(logic [2:0] cmd, logic [23:0] d);
    int gap;
    gap = $urandom_range(0, 7) == 0 ? $urandom_range(1, gap_max) : 0;
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(uart_predict(cmd, d));
  endtask

  function automatic logic [23:0] pack_item(logic [2:0] a, logic [7:0] wd, logic [7:0] lb,
                                            logic pe, logic fe, logic br);
    return {2'd0, br, fe, pe, lb, wd, a};
  endfunction

  task automatic bus_wr(logic [2:0] a, logic [7:0] wd);
    send_item(CMD_WRITE, pack_item(a, wd, 8'($urandom), 1'($urandom), 1'($urandom),
                                   1'($urandom)));
  endtask
  task automatic bus_rd(logic [2:0] a);
    send_item(CMD_READ, pack_item(a, 8'($urandom), 8'($urandom), 1'($urandom),
                                  1'($urandom), 1'($urandom)));
  endtask
  task automatic line_rx(logic [7:0] lb, logic pe, logic fe, logic br);
    send_item(CMD_RX_BYTE, pack_item(3'($urandom), 8'($urandom), lb, pe, fe, br));
  endtask
  task automatic other_cmd(logic [2:0] cmd);
    send_item(cmd, 24'($urandom));
  endtask

  task automatic drain_wait();
    int n;
    n = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0 && n < 100000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_variant(logic [1:0] v);
    drain_wait();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_variant(v);
  endtask

  task automatic test_directed();
    bus_wr(REG_MCR, 8'hff);
    bus_wr(REG_IER, 8'h0f);
    bus_rd(REG_IIR);
    bus_rd(REG_DATA);
    bus_wr(REG_LCR, 8'h80);
    bus_wr(REG_DATA, 8'hff);
    bus_wr(REG_IER, 8'h00);
    bus_rd(REG_DATA);
    bus_rd(REG_IER);
    bus_wr(REG_LCR, 8'h03);
    bus_wr(REG_IIR, 8'hc7);
    line_rx(8'hff, 1, 0, 0);
    line_rx(8'h55, 0, 1, 1);
    bus_rd(REG_LSR);
    bus_rd(REG_IIR);
    other_cmd(CMD_TIMEOUT);
    bus_rd(REG_IIR);
    bus_rd(REG_DATA);
    bus_wr(REG_DATA, 8'h00);
    bus_wr(REG_DATA, 8'ha5);
    other_cmd(CMD_TX_DONE);
    other_cmd(CMD_TX_DONE);
    other_cmd(CMD_TX_DONE);
    bus_wr(REG_SCR, 8'h5a);
    bus_rd(REG_SCR);
    other_cmd(3'd7);
  endtask

  task automatic test_random(int count);
    int k, pick;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) line_rx(8'($urandom), $urandom_range(0, 9) == 0,
                             $urandom_range(0, 9) == 0, $urandom_range(0, 19) == 0);
      else if (pick < 45) bus_rd($urandom_range(0, 9) < 6 ? REG_DATA : 3'($urandom));
      else if (pick < 62) bus_wr(REG_DATA, 8'($urandom));
      else if (pick < 75) other_cmd(CMD_TX_DONE);
      else if (pick < 80) other_cmd(CMD_TIMEOUT);
      else if (pick < 83) bus_wr(REG_IIR, {3'($urandom_range(0, 7)), 5'd0} |
                                 ($urandom_range(0, 3) == 0 ? 8'h07 : 8'h01));
      else if (pick < 86) bus_wr(REG_LCR, $urandom_range(0, 7) == 0 ?
                                 8'h80 | 8'($urandom) : 8'($urandom) & 8'h7f);
      else if (pick < 89) bus_wr(REG_IER, 8'($urandom));
      else if (pick < 91) bus_wr(REG_MCR, 8'($urandom));
      else if (pick < 93) bus_wr(3'($urandom), 8'($urandom));
      else if (pick < 99) bus_rd(3'($urandom_range(REG_IIR, REG_SCR)));
      else other_cmd(3'($urandom_range(5, 7)));
    end
  endtask

  // Fills the receive FIFO past its capacity while the receiver is held off.
  task automatic test_backpressure();
    int k;
    drain_wait();
    bus_wr(REG_IIR, 8'h27);
    long_stall = 1;
    for (k = 0; k < 70; k++) line_rx(8'($urandom), 0, 0, 0);
    for (k = 0; k < 70; k++) bus_rd(REG_DATA);
  endtask

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (long_stall) begin
        long_stall = 0;
        m_axis_tready <= 1'b0;
        for (n = 0; n < 300; n++) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(0, 3) != 0);
      @(posedge clk_i);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    logic [39:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (want[7:0] !== m_axis_tdata[7:0])
          $display("%0t: read_data expected %h actual %h", $time, want[7:0],
                   m_axis_tdata[7:0]);
        if (want[8] !== m_axis_tdata[8])
          $display("%0t: irq_out expected %b actual %b", $time, want[8], m_axis_tdata[8]);
        if (want[9] !== m_axis_tdata[9])
          $display("%0t: tx_start expected %b actual %b", $time, want[9], m_axis_tdata[9]);
        if (want[17:10] !== m_axis_tdata[17:10])
          $display("%0t: tx_byte expected %h actual %h", $time, want[17:10],
                   m_axis_tdata[17:10]);
        if (want[33:18] !== m_axis_tdata[33:18])
          $display("%0t: baud_divisor expected %h actual %h", $time, want[33:18],
                   m_axis_tdata[33:18]);
        if (want !== m_axis_tdata) errors++;
      end
    end
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    model_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    set_variant(VAR_16);
    test_random(400);
    set_variant(VAR_NONE);
    bus_wr(REG_IIR, 8'h07);
    test_random(300);
    set_variant(2'd3);
    test_backpressure();
    gap_max = 20;
    test_random(350);
    gap_max = 3;
    set_variant(VAR_16);
    test_random(300);
    set_variant(VAR_64);
    test_random(300);
    drain_wait();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
